/* hw/rtl/pcvs_pkg.sv */
package pcvs_pkg;

    localparam int MaxPoints  = 64;
    localparam int AddrW      = $clog2(MaxPoints);
    localparam int CntW       = $clog2(MaxPoints + 1);
    localparam int FifoDepth  = 4;
    localparam int FifoPtrW   = $clog2(FifoDepth);
    localparam int FifoCntW   = $clog2(FifoDepth + 1);
    localparam int QuoW       = 51;
    localparam int NumW       = 93;
    localparam int DenW       = 64;
    localparam int AccW       = 58;
    localparam int InDataW    = 184;

    localparam logic [29:0]     KInvTwoPi = 30'd683565276;
    localparam logic [QuoW-1:0] TermCap   = {1'b1, {(QuoW-1){1'b0}}};
    localparam logic signed [AccW-1:0] PotMax = 58'sd140737488355327;
    localparam logic signed [AccW-1:0] PotMin = -58'sd140737488355328;
    localparam logic [6:0]      PointCountReset = 7'd64;

    typedef struct packed {
        logic        is_eval;
        logic [AddrW-1:0] idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] q;
        logic [47:0] pot;
        logic [31:0] tym;
        logic [31:0] tzm;
        logic        tyn;
        logic        tzn;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic neg;
        logic sat;
        logic last;
    } t_tag;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

/* hw/rtl/particle_cluster_vortex_sum.sv */
// load word: registered, queued, then written to the point store when the back end is idle
// evaluate word: result once the last of point_count terms is summed (no terms for
// point_count zero), set by one term per cycle from the point store, a 6-stage term
// pipeline and the 52-register divider
// no new evaluate until the last is done and its result taken; a 4-entry queue absorbs input
// reset: synchronous active low, clears queue, pipeline valids, output; point_count = 64
module particle_cluster_vortex_sum (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // point_index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
    // point_charge[133:102], potential_in[181:134], zero fill
    input  logic [183:0] i_s_axis_tdata,
    // opcode[0]
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // potential_out[47:0]
    output logic [47:0]  o_m_axis_tdata,
    // singular_flag[0]
    output logic         o_m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [6:0]     r_point_count;
    logic           cfg_wr;
    logic           fe_push;
    pcvs_pkg::t_cmd fe_cmd;
    logic           q_ready;
    logic           q_valid;
    pcvs_pkg::t_cmd q_cmd;
    logic           be_pop;
    logic           be_busy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = !paddr[2] ? {25'b0, r_point_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= pcvs_pkg::PointCountReset;
        end else if (cfg_wr) begin
            r_point_count <= pwdata[6:0];
        end
    end

    pcvs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .i_user       (i_s_axis_tuser),
        .o_push       (fe_push),
        .o_cmd        (fe_cmd),
        .i_fifo_ready (q_ready)
    );

    pcvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_cmd   (fe_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (be_pop)
    );

    pcvs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_count (r_point_count),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (be_pop),
        .o_busy        (be_busy),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_potential   (o_m_axis_tdata),
        .o_flag        (o_m_axis_tuser)
    );

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> r_point_count == $past(pwdata[6:0]))
        else $error("point_count write lost");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(be_busy))
        else $error("result without an evaluate in progress");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_queue_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_pop |-> q_valid && !be_busy)
        else $error("queue popped while back end busy");

endmodule

/* hw/rtl/pcvs_front.sv */
module pcvs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [pcvs_pkg::InDataW-1:0] i_data,
    input  logic                 i_user,
    output logic                 o_push,
    output pcvs_pkg::t_cmd       o_cmd,
    input  logic                 i_fifo_ready
);

    logic           r_valid;
    pcvs_pkg::t_cmd r_cmd;
    pcvs_pkg::t_cmd n_cmd;
    logic           accept;

    assign o_ready = !r_valid || i_fifo_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.is_eval = i_user;
        n_cmd.idx     = i_data[5:0];
        n_cmd.x       = i_data[37:6];
        n_cmd.y       = i_data[69:38];
        n_cmd.z       = i_data[101:70];
        n_cmd.q       = i_data[133:102];
        n_cmd.pot     = i_data[181:134];
        n_cmd.tym     = pcvs_pkg::mag32(i_data[69:38]);
        n_cmd.tzm     = pcvs_pkg::mag32(i_data[101:70]);
        n_cmd.tyn     = i_data[69];
        n_cmd.tzn     = i_data[101];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_fifo_ready);
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* hw/rtl/pcvs_fifo.sv */
module pcvs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcvs_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output pcvs_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    pcvs_pkg::t_cmd                     r_mem [pcvs_pkg::FifoDepth];
    logic [pcvs_pkg::FifoPtrW-1:0]      r_wp;
    logic [pcvs_pkg::FifoPtrW-1:0]      r_rp;
    logic [pcvs_pkg::FifoCntW-1:0]      r_cnt;
    logic                               do_push;
    logic                               do_pop;

    assign o_ready = r_cnt != pcvs_pkg::FifoCntW'(pcvs_pkg::FifoDepth);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/pcvs_div.sv */
module pcvs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [pcvs_pkg::NumW-1:0]     i_num,
    input  logic [pcvs_pkg::DenW-1:0]     i_den,
    input  pcvs_pkg::t_tag                i_tag,
    output logic                          o_valid,
    output logic [pcvs_pkg::QuoW-1:0]     o_quo,
    output pcvs_pkg::t_tag                o_tag
);

    localparam int QW = pcvs_pkg::QuoW;
    localparam int DW = pcvs_pkg::DenW;

    logic [DW-1:0]  r_rem [QW+1];
    logic [QW-1:0]  r_low [QW+1];
    logic [QW-1:0]  r_q   [QW+1];
    logic [DW-1:0]  r_den [QW+1];
    pcvs_pkg::t_tag r_tag [QW+1];
    logic [QW:0]    r_v;

    logic [DW-1:0]  n_rem [QW+1];
    logic [QW-1:0]  n_q   [QW+1];
    logic [DW:0]    trial [QW];
    pcvs_pkg::t_tag in_tag;

    always_comb begin
        in_tag     = i_tag;
        in_tag.sat = i_num[pcvs_pkg::NumW-1:QW] >= i_den;
        n_rem[0]   = '0;
        n_q[0]     = '0;
        for (int k = 0; k < QW; k++) begin
            trial[k] = {r_rem[k], r_low[k][QW-1]};
            if (trial[k] >= {1'b0, r_den[k]}) begin
                n_rem[k+1] = DW'(trial[k] - {1'b0, r_den[k]});
                n_q[k+1]   = {r_q[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k+1] = trial[k][DW-1:0];
                n_q[k+1]   = {r_q[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
        r_rem[0] <= DW'(i_num[pcvs_pkg::NumW-1:QW]);
        r_low[0] <= i_num[QW-1:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_tag[0] <= in_tag;
        for (int k = 0; k < QW; k++) begin
            r_rem[k+1] <= n_rem[k+1];
            r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
            r_q[k+1]   <= n_q[k+1];
            r_den[k+1] <= r_den[k];
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_q[QW];
    assign o_tag   = r_tag[QW];

endmodule

/* hw/rtl/pcvs_back.sv */
module pcvs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [6:0]     i_point_count,
    input  logic           i_cmd_valid,
    input  pcvs_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_busy,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [47:0]    o_potential,
    output logic           o_flag
);

    localparam int AW = pcvs_pkg::AddrW;
    localparam int CW = pcvs_pkg::CntW;

    pcvs_pkg::t_state r_state;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    cnt_lim;

    logic [31:0] r_tx, r_ty, r_tz, r_tym, r_tzm;
    logic        r_tyn, r_tzn;

    logic [127:0] r_mem [pcvs_pkg::MaxPoints];
    logic [127:0] r_rd;
    logic         mem_we;

    logic r_s0_v, r_s0_last;

    logic        r1_v, r1_last, r1_czn, r1_cyn, r1_qn;
    logic [31:0] r1_czm, r1_cym, r1_qm, r1_adx, r1_ady, r1_adz;
    logic [32:0] dx, dy, dz, adx, ady, adz;

    logic        r2_v, r2_last, r2_n1, r2_n2, r2_qn;
    logic [63:0] r2_m1, r2_m2;
    logic [31:0] r2_qm;
    logic [61:0] r2_sqx, r2_sqy, r2_sqz;
    logic [63:0] p_sqx, p_sqy, p_sqz;

    logic        r3_v, r3_last, r3_crossn, r3_qn;
    logic [31:0] r3_cm, r3_qm;
    logic [63:0] r3_norm;
    logic        n1, n2, crossn;
    logic [63:0] cross_m;

    logic        r4_v, r4_last, r4_neg;
    logic [62:0] r4_p;
    logic [63:0] r4_norm;
    logic [63:0] p_full;

    logic        r5_v, r5_last, r5_neg;
    logic [61:0] r5_lo;
    logic [60:0] r5_hi;
    logic [63:0] r5_norm;

    logic                      r6_v;
    logic [pcvs_pkg::NumW-1:0] r6_num;
    logic [63:0]               r6_norm;
    pcvs_pkg::t_tag            r6_tag;

    logic                      d_v;
    logic [pcvs_pkg::QuoW-1:0] d_q;
    pcvs_pkg::t_tag            d_tag;
    logic [pcvs_pkg::QuoW-1:0] term;

    logic signed [pcvs_pkg::AccW-1:0] r_acc;
    logic                             r_flag;
    logic                             r_out_v;
    logic [47:0]                      r_out_pot;
    logic                             r_out_flag;

    assign cnt_lim = (i_point_count > 7'(pcvs_pkg::MaxPoints))
                     ? CW'(pcvs_pkg::MaxPoints) : CW'(i_point_count);
    assign o_pop   = (r_state == pcvs_pkg::S_IDLE) && i_cmd_valid
                     && (!i_cmd.is_eval || !r_out_v);
    assign mem_we  = o_pop && !i_cmd.is_eval;
    assign o_busy  = r_state != pcvs_pkg::S_IDLE;
    assign o_valid     = r_out_v;
    assign o_potential = r_out_pot;
    assign o_flag      = r_out_flag;

    // point store: x, y, z, charge
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.idx] <= {i_cmd.q, i_cmd.z, i_cmd.y, i_cmd.x};
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pcvs_pkg::S_IDLE;
            r_idx     <= '0;
            r_s0_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_flag    <= 1'b0;
        end else begin
            r_s0_v <= 1'b0;
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                pcvs_pkg::S_IDLE: begin
                    if (o_pop && i_cmd.is_eval) begin
                        r_idx  <= '0;
                        r_n    <= cnt_lim;
                        r_flag <= 1'b0;
                        r_acc  <= {{(pcvs_pkg::AccW-48){i_cmd.pot[47]}}, i_cmd.pot};
                        r_tx   <= i_cmd.x;
                        r_ty   <= i_cmd.y;
                        r_tz   <= i_cmd.z;
                        r_tym  <= i_cmd.tym;
                        r_tzm  <= i_cmd.tzm;
                        r_tyn  <= i_cmd.tyn;
                        r_tzn  <= i_cmd.tzn;
                        r_state <= (cnt_lim == '0) ? pcvs_pkg::S_FIN : pcvs_pkg::S_RUN;
                    end
                end
                pcvs_pkg::S_RUN: begin
                    r_s0_v    <= 1'b1;
                    r_s0_last <= r_idx == r_n - 1'b1;
                    r_idx     <= r_idx + 1'b1;
                    if (r_idx == r_n - 1'b1) begin
                        r_state <= pcvs_pkg::S_DRAIN;
                    end
                    // early terms come back while later ones are still issued
                    if (d_v) begin
                        if (d_tag.zero) begin
                            r_flag <= 1'b1;
                        end else if (d_tag.neg) begin
                            r_acc <= r_acc - $signed({7'b0, term});
                        end else begin
                            r_acc <= r_acc + $signed({7'b0, term});
                        end
                    end
                end
                pcvs_pkg::S_DRAIN: begin
                    if (d_v) begin
                        if (d_tag.zero) begin
                            r_flag <= 1'b1;
                        end else if (d_tag.neg) begin
                            r_acc <= r_acc - $signed({7'b0, term});
                        end else begin
                            r_acc <= r_acc + $signed({7'b0, term});
                        end
                        if (d_tag.last) begin
                            r_state <= pcvs_pkg::S_FIN;
                        end
                    end
                end
                pcvs_pkg::S_FIN: begin
                    r_out_v    <= 1'b1;
                    r_out_flag <= r_flag;
                    if (r_acc > pcvs_pkg::PotMax) begin
                        r_out_pot <= pcvs_pkg::PotMax[47:0];
                    end else if (r_acc < pcvs_pkg::PotMin) begin
                        r_out_pot <= pcvs_pkg::PotMin[47:0];
                    end else begin
                        r_out_pot <= r_acc[47:0];
                    end
                    r_state <= pcvs_pkg::S_IDLE;
                end
                default: begin
                    r_state <= pcvs_pkg::S_IDLE;
                end
            endcase
        end
    end

    // term pipeline
    always_comb begin
        dx  = {r_rd[31], r_rd[31:0]} - {r_tx[31], r_tx};
        dy  = {r_rd[63], r_rd[63:32]} - {r_ty[31], r_ty};
        dz  = {r_rd[95], r_rd[95:64]} - {r_tz[31], r_tz};
        adx = dx[32] ? (33'd0 - dx) : dx;
        ady = dy[32] ? (33'd0 - dy) : dy;
        adz = dz[32] ? (33'd0 - dz) : dz;

        p_sqx = r1_adx * r1_adx;
        p_sqy = r1_ady * r1_ady;
        p_sqz = r1_adz * r1_adz;

        n1 = r2_n1 && (r2_m1 != '0);
        n2 = r2_n2 && (r2_m2 != '0);
        if (n1 == n2) begin
            if (r2_m1 >= r2_m2) begin
                cross_m = r2_m1 - r2_m2;
                crossn  = n1;
            end else begin
                cross_m = r2_m2 - r2_m1;
                crossn  = !n1;
            end
        end else begin
            cross_m = r2_m1 + r2_m2;
            crossn  = n1;
        end

        p_full = r3_cm * r3_qm;

        term = (d_tag.sat || d_q > pcvs_pkg::TermCap) ? pcvs_pkg::TermCap : d_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= r_s0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end

        r1_last <= r_s0_last;
        r1_cym  <= pcvs_pkg::mag32(r_rd[63:32]);
        r1_cyn  <= r_rd[63];
        r1_czm  <= pcvs_pkg::mag32(r_rd[95:64]);
        r1_czn  <= r_rd[95];
        r1_qm   <= pcvs_pkg::mag32(r_rd[127:96]);
        r1_qn   <= r_rd[127];
        r1_adx  <= adx[31:0];
        r1_ady  <= ady[31:0];
        r1_adz  <= adz[31:0];

        r2_last <= r1_last;
        r2_m1   <= r_tym * r1_czm;
        r2_m2   <= r_tzm * r1_cym;
        r2_n1   <= r_tyn != r1_czn;
        r2_n2   <= r_tzn != r1_cyn;
        r2_qm   <= r1_qm;
        r2_qn   <= r1_qn;
        r2_sqx  <= p_sqx[63:2];
        r2_sqy  <= p_sqy[63:2];
        r2_sqz  <= p_sqz[63:2];

        r3_last   <= r2_last;
        r3_cm     <= cross_m[63:32];
        r3_crossn <= crossn;
        r3_qm     <= r2_qm;
        r3_qn     <= r2_qn;
        r3_norm   <= {2'b0, r2_sqx} + {2'b0, r2_sqy} + {2'b0, r2_sqz};

        r4_last <= r3_last;
        r4_p    <= p_full[62:0];
        r4_neg  <= r3_crossn == r3_qn;
        r4_norm <= r3_norm;

        r5_last <= r4_last;
        r5_lo   <= r4_p[31:0] * pcvs_pkg::KInvTwoPi;
        r5_hi   <= r4_p[62:32] * pcvs_pkg::KInvTwoPi;
        r5_neg  <= r4_neg;
        r5_norm <= r4_norm;

        r6_num      <= {r5_hi, 32'b0} + {31'b0, r5_lo};
        r6_norm     <= r5_norm;
        r6_tag.zero <= r5_norm == '0;
        r6_tag.neg  <= r5_neg;
        r6_tag.sat  <= 1'b0;
        r6_tag.last <= r5_last;
    end

    pcvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .i_num   (r6_num),
        .i_den   (r6_norm),
        .i_tag   (r6_tag),
        .o_valid (d_v),
        .o_quo   (d_q),
        .o_tag   (d_tag)
    );

endmodule
